FILE: design/assert_macros.svh
// assertion macros for the soft mask blend block
// used by the top level only, needs a clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/rcsm_pkg.sv
// shared types, constants and tables for the soft mask blend pipeline
// no dependencies
`default_nettype none

package rcsm_pkg;

  localparam int COORD_BITS = 12;
  localparam int CORDIC_STEPS = 16;

  localparam int IN_BITS = 3 * COORD_BITS + 32 + 17;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  localparam int SUMSQ_W = 2 * COORD_BITS;
  localparam int RAD_W = SUMSQ_W + 16;
  localparam int ROOT_W = RAD_W / 2;

  localparam int SQ_PER = 2;
  localparam int SQ_STAGES = (ROOT_W + SQ_PER - 1) / SQ_PER;

  localparam int DIV_STEPS = 17;
  localparam int DIV_PER = 3;
  localparam int DIV_STAGES = (DIV_STEPS + DIV_PER - 1) / DIV_PER;

  localparam int CO_PER = 2;
  localparam int CO_STAGES = (CORDIC_STEPS + CO_PER - 1) / CO_PER;
  localparam int CO_W = 34;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [16:0] HALF_Q16 = 17'd32768;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic signed [CO_W-1:0] GAIN_Q30 = 34'sd652032874;

  localparam logic [1:0] REG_INNER = 2'd0;
  localparam logic [1:0] REG_EDGE = 2'd1;
  localparam logic [1:0] REG_BG = 2'd2;
  localparam logic [1:0] REG_SRC = 2'd3;

  typedef struct packed {
    logic signed [31:0] pixel;
    logic [16:0] alpha_w;
    logic outer;
    logic band;
    logic neg;
    logic tzero;
  } side_t;

  function automatic logic signed [CO_W-1:0] cordic_atan(input int i);
    logic signed [CO_W-1:0] a;
    unique case (i)
      0: a = 34'sd843314857;
      1: a = 34'sd497837830;
      2: a = 34'sd263043837;
      3: a = 34'sd133525159;
      4: a = 34'sd67021687;
      5: a = 34'sd33543516;
      6: a = 34'sd16775851;
      7: a = 34'sd8388437;
      8: a = 34'sd4194283;
      9: a = 34'sd2097149;
      10: a = 34'sd1048576;
      11: a = 34'sd524288;
      12: a = 34'sd262144;
      13: a = 34'sd131072;
      14: a = 34'sd65536;
      15: a = 34'sd32768;
      16: a = 34'sd16384;
      17: a = 34'sd8192;
      18: a = 34'sd4096;
      19: a = 34'sd2048;
      20: a = 34'sd1024;
      21: a = 34'sd512;
      22: a = 34'sd256;
      default: a = 34'sd128;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

FILE: design/rcsm_sqrt.sv
// pipelined digit-by-digit integer square root, two result bits per stage
// depends on rcsm_pkg
`default_nettype none

module rcsm_sqrt (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_vld,
  input  wire logic [rcsm_pkg::RAD_W-1:0] radicand,
  input  wire rcsm_pkg::side_t in_side,
  output logic out_vld,
  output logic [rcsm_pkg::ROOT_W-1:0] root,
  output rcsm_pkg::side_t out_side
);
  import rcsm_pkg::*;

  localparam int REM_W = ROOT_W + 3;

  logic [SQ_STAGES-1:0] vld_q;
  logic [RAD_W-1:0] rad_q [SQ_STAGES];
  logic [REM_W-1:0] rem_q [SQ_STAGES];
  logic [ROOT_W-1:0] root_q [SQ_STAGES];
  side_t side_q [SQ_STAGES];

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
    logic vld_i;
    logic [RAD_W-1:0] rad_i, rad_c;
    logic [REM_W-1:0] rem_i, rem_c, trial;
    logic [ROOT_W-1:0] root_i, root_c;
    side_t side_i;

    if (g == 0) begin : g_first
      assign vld_i = in_vld;
      assign rad_i = radicand;
      assign rem_i = '0;
      assign root_i = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i = vld_q[g-1];
      assign rad_i = rad_q[g-1];
      assign rem_i = rem_q[g-1];
      assign root_i = root_q[g-1];
      assign side_i = side_q[g-1];
    end

    always_comb begin
      rad_c = rad_i;
      rem_c = rem_i;
      root_c = root_i;
      trial = '0;
      for (int k = 0; k < SQ_PER; k++) begin
        if (g * SQ_PER + k < ROOT_W) begin
          rem_c = {rem_c[REM_W-3:0], rad_c[RAD_W-1 -: 2]};
          rad_c = rad_c << 2;
          trial = {1'b0, root_c, 2'b01};
          if (rem_c >= trial) begin
            rem_c = rem_c - trial;
            root_c = {root_c[ROOT_W-2:0], 1'b1};
          end else begin
            root_c = {root_c[ROOT_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[g] <= 1'b0;
      end else if (en) begin
        vld_q[g] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[g] <= rad_c;
        rem_q[g] <= rem_c;
        root_q[g] <= root_c;
        side_q[g] <= side_i;
      end
    end
  end

  assign out_vld = vld_q[SQ_STAGES-1];
  assign root = root_q[SQ_STAGES-1];
  assign out_side = side_q[SQ_STAGES-1];

endmodule

`default_nettype wire

FILE: design/rcsm_div.sv
// pipelined restoring divider for the edge band fraction (d << 16) / ew
// depends on rcsm_pkg
`default_nettype none

module rcsm_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_vld,
  input  wire logic [19:0] dividend,
  input  wire logic [19:0] divisor,
  input  wire rcsm_pkg::side_t in_side,
  output logic out_vld,
  output logic [16:0] quotient,
  output rcsm_pkg::side_t out_side
);
  import rcsm_pkg::*;

  logic [DIV_STAGES-1:0] vld_q;
  logic [20:0] rem_q [DIV_STAGES];
  logic [16:0] quo_q [DIV_STAGES];
  side_t side_q [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic vld_i;
    logic [20:0] rem_i, rem_c;
    logic [16:0] quo_i, quo_c;
    side_t side_i;

    if (g == 0) begin : g_first
      assign vld_i = in_vld;
      assign rem_i = {1'b0, dividend};
      assign quo_i = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i = vld_q[g-1];
      assign rem_i = rem_q[g-1];
      assign quo_i = quo_q[g-1];
      assign side_i = side_q[g-1];
    end

    // compare, subtract, then shift the partial remainder
    always_comb begin
      rem_c = rem_i;
      quo_c = quo_i;
      for (int k = 0; k < DIV_PER; k++) begin
        if (g * DIV_PER + k < DIV_STEPS) begin
          if (rem_c >= {1'b0, divisor}) begin
            rem_c = rem_c - {1'b0, divisor};
            quo_c = {quo_c[15:0], 1'b1};
          end else begin
            quo_c = {quo_c[15:0], 1'b0};
          end
          rem_c = rem_c << 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[g] <= 1'b0;
      end else if (en) begin
        vld_q[g] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[g] <= rem_c;
        quo_q[g] <= quo_c;
        side_q[g] <= side_i;
      end
    end
  end

  assign out_vld = vld_q[DIV_STAGES-1];
  assign quotient = quo_q[DIV_STAGES-1];
  assign out_side = side_q[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: design/rcsm_cordic.sv
// pipelined rotation-mode cordic giving the cosine in q4.30
// depends on rcsm_pkg for the gain and the arctangent table
`default_nettype none

module rcsm_cordic (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_vld,
  input  wire logic signed [rcsm_pkg::CO_W-1:0] angle,
  input  wire rcsm_pkg::side_t in_side,
  output logic out_vld,
  output logic signed [rcsm_pkg::CO_W-1:0] cos_x,
  output rcsm_pkg::side_t out_side
);
  import rcsm_pkg::*;

  logic [CO_STAGES-1:0] vld_q;
  logic signed [CO_W-1:0] x_q [CO_STAGES];
  logic signed [CO_W-1:0] y_q [CO_STAGES];
  logic signed [CO_W-1:0] z_q [CO_STAGES];
  side_t side_q [CO_STAGES];

  for (genvar g = 0; g < CO_STAGES; g++) begin : g_stage
    logic vld_i;
    logic signed [CO_W-1:0] x_i, y_i, z_i, x_c, y_c, z_c, xs, ys;
    side_t side_i;

    if (g == 0) begin : g_first
      assign vld_i = in_vld;
      assign x_i = GAIN_Q30;
      assign y_i = '0;
      assign z_i = angle;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i = vld_q[g-1];
      assign x_i = x_q[g-1];
      assign y_i = y_q[g-1];
      assign z_i = z_q[g-1];
      assign side_i = side_q[g-1];
    end

    always_comb begin
      x_c = x_i;
      y_c = y_i;
      z_c = z_i;
      xs = '0;
      ys = '0;
      for (int k = 0; k < CO_PER; k++) begin
        if (g * CO_PER + k < CORDIC_STEPS) begin
          xs = x_c >>> (g * CO_PER + k);
          ys = y_c >>> (g * CO_PER + k);
          if (!z_c[CO_W-1]) begin
            x_c = x_c - ys;
            y_c = y_c + xs;
            z_c = z_c - cordic_atan(g * CO_PER + k);
          end else begin
            x_c = x_c + ys;
            y_c = y_c - xs;
            z_c = z_c + cordic_atan(g * CO_PER + k);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[g] <= 1'b0;
      end else if (en) begin
        vld_q[g] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_q[g] <= x_c;
        y_q[g] <= y_c;
        z_q[g] <= z_c;
        side_q[g] <= side_i;
      end
    end
  end

  assign out_vld = vld_q[CO_STAGES-1];
  assign cos_x = x_q[CO_STAGES-1];
  assign out_side = side_q[CO_STAGES-1];

endmodule

`default_nettype wire

FILE: design/raised_cosine_soft_mask_blend.sv
// Raised-cosine soft mask blend, one pixel or voxel per item.
// Input stream s_*: tdata carries col_pos, row_pos, slice_pos (signed,
// COORD_BITS each), pixel_value (signed Q16.16) and alpha_value (Q1.16).
// Output stream m_*: tdata carries masked_value, signed Q16.16.
// Registers over APB: inner_radius @0x0, edge_width @0x4,
// background_level @0x8, weight_source @0xC; write only while idle.
// The pipeline has 30 register stages: squares 1, range compare 1,
// square root 10, edge fraction divider 6, angle multiply 1, cordic 8,
// weight 1, products 1, rounding 1.
// Throughput is one item per clock while m_tready is high; every item
// moves down a single valid-tagged pipeline.
// When m_tready is low with a result waiting, the whole pipeline holds
// and s_tready drops; items already inside are kept, nothing is lost.
// Reset (rst, synchronous) empties the pipeline and clears the valid flags
// and the configuration registers to zero; no clearing pass is needed.
// depends on rcsm_pkg, rcsm_sqrt, rcsm_div, rcsm_cordic, assert_macros.svh
`default_nettype none

module raised_cosine_soft_mask_blend (
  input  wire logic clk,
  input  wire logic rst,
  // apb register port
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [3:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  // tdata: col_pos, row_pos, slice_pos, pixel_value, alpha_value, zero pad
  input  wire logic s_tvalid,
  output logic s_tready,
  input  wire logic [rcsm_pkg::IN_TDATA_W-1:0] s_tdata,
  // tdata: masked_value
  output logic m_tvalid,
  input  wire logic m_tready,
  output logic [31:0] m_tdata
);
  import rcsm_pkg::*;

  localparam int CB = COORD_BITS;

  // registers
  logic [19:0] inner_radius, edge_width;
  logic signed [31:0] background_level;
  logic weight_source;
  logic [39:0] r_sq;
  logic [41:0] outer_sq;
  logic [20:0] outer_r;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign outer_r = {1'b0, inner_radius} + {1'b0, edge_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_radius <= '0;
      edge_width <= '0;
      background_level <= '0;
      weight_source <= 1'b0;
      r_sq <= '0;
      outer_sq <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_INNER: inner_radius <= pwdata[19:0];
          REG_EDGE: edge_width <= pwdata[19:0];
          REG_BG: background_level <= pwdata;
          REG_SRC: weight_source <= pwdata[0];
          default: ;
        endcase
      end
      r_sq <= inner_radius * inner_radius;
      outer_sq <= outer_r * outer_r;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_INNER: prdata = {12'd0, inner_radius};
      REG_EDGE: prdata = {12'd0, edge_width};
      REG_BG: prdata = background_level;
      REG_SRC: prdata = {31'd0, weight_source};
      default: prdata = '0;
    endcase
  end

  logic adv;
  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;

  // stage 0: squares and alpha weight
  logic signed [CB-1:0] cx, cy, cz;
  logic [16:0] alpha_in, alpha_w;
  logic [SUMSQ_W-1:0] sq_x, sq_y, sq_z;
  logic s0_vld;
  logic [SUMSQ_W-1:0] s0_sum;
  side_t s0_side;

  assign cx = s_tdata[CB-1:0];
  assign cy = s_tdata[2*CB-1:CB];
  assign cz = s_tdata[3*CB-1:2*CB];
  assign alpha_in = s_tdata[3*CB+48:3*CB+32];
  assign alpha_w = (alpha_in > ONE_Q16) ? 17'd0 : ONE_Q16 - alpha_in;
  assign sq_x = $unsigned(SUMSQ_W'(cx) * SUMSQ_W'(cx));
  assign sq_y = $unsigned(SUMSQ_W'(cy) * SUMSQ_W'(cy));
  assign sq_z = $unsigned(SUMSQ_W'(cz) * SUMSQ_W'(cz));

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (adv) begin
      s0_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_sum <= sq_x + sq_y + sq_z;
      s0_side.pixel <= s_tdata[3*CB+31:3*CB];
      s0_side.alpha_w <= alpha_w;
      s0_side.outer <= 1'b0;
      s0_side.band <= 1'b0;
      s0_side.neg <= 1'b0;
      s0_side.tzero <= 1'b0;
    end
  end

  // stage 1: region of the squared distance
  logic [RAD_W-1:0] s_full;
  logic s1_vld;
  logic [RAD_W-1:0] s1_rad;
  side_t s1_side, s1_side_next;

  assign s_full = {s0_sum, 16'd0};

  always_comb begin
    s1_side_next = s0_side;
    s1_side_next.outer = {2'd0, s_full} > outer_sq;
    s1_side_next.band = !({2'd0, s_full} > outer_sq) && (s_full >= r_sq)
                        && (edge_width != 20'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= s0_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_rad <= s_full;
      s1_side <= s1_side_next;
    end
  end

  // distance in q.8
  logic sq_vld;
  logic [ROOT_W-1:0] root_q8;
  side_t sq_side;

  rcsm_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(adv),
    .in_vld(s1_vld), .radicand(s1_rad), .in_side(s1_side),
    .out_vld(sq_vld), .root(root_q8), .out_side(sq_side)
  );

  // fraction of the edge band crossed
  logic dv_vld;
  logic [16:0] frac;
  logic [19:0] band_d;
  side_t dv_side;

  assign band_d = 20'(root_q8 - ROOT_W'(inner_radius));

  rcsm_div u_div (
    .clk(clk), .rst(rst), .en(adv),
    .in_vld(sq_vld), .dividend(band_d), .divisor(edge_width), .in_side(sq_side),
    .out_vld(dv_vld), .quotient(frac), .out_side(dv_side)
  );

  // fold the far half onto the near half, scale by pi
  logic [16:0] t_clamp, t_fold;
  logic [47:0] ang_prod;
  logic an_vld;
  logic signed [CO_W-1:0] an_z;
  side_t an_side, an_side_next;

  assign t_clamp = (frac > ONE_Q16) ? ONE_Q16 : frac;
  assign t_fold = (t_clamp > HALF_Q16) ? ONE_Q16 - t_clamp : t_clamp;
  assign ang_prod = t_fold[15:0] * PI_Q30;

  always_comb begin
    an_side_next = dv_side;
    an_side_next.neg = t_clamp > HALF_Q16;
    an_side_next.tzero = t_fold == 17'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      an_vld <= 1'b0;
    end else if (adv) begin
      an_vld <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      an_z <= {2'b00, ang_prod[47:16]};
      an_side <= an_side_next;
    end
  end

  logic co_vld;
  logic signed [CO_W-1:0] co_x;
  side_t co_side;

  rcsm_cordic u_cordic (
    .clk(clk), .rst(rst), .en(adv),
    .in_vld(an_vld), .angle(an_z), .in_side(an_side),
    .out_vld(co_vld), .cos_x(co_x), .out_side(co_side)
  );

  // weight stage
  logic signed [CO_W-1:0] x_rnd;
  logic signed [18:0] c_raw;
  logic signed [17:0] c_clamp, c_sgn, w_cos;
  logic [16:0] w_sel;
  logic wt_vld;
  logic [16:0] wt_w;
  logic signed [31:0] wt_pix;

  assign x_rnd = co_x + 34'sd16384;
  assign c_raw = 19'(x_rnd >>> 15);

  always_comb begin
    if (co_side.tzero || c_raw > 19'sd32768) begin
      c_clamp = 18'sd32768;
    end else if (c_raw < -19'sd32768) begin
      c_clamp = -18'sd32768;
    end else begin
      c_clamp = 18'(c_raw);
    end
    c_sgn = co_side.neg ? -c_clamp : c_clamp;
    w_cos = 18'sd32768 - c_sgn;
    priority if (weight_source) begin
      w_sel = co_side.alpha_w;
    end else if (co_side.outer) begin
      w_sel = ONE_Q16;
    end else if (co_side.band) begin
      w_sel = w_cos[16:0];
    end else begin
      w_sel = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wt_vld <= 1'b0;
    end else if (adv) begin
      wt_vld <= co_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wt_w <= w_sel;
      wt_pix <= co_side.pixel;
    end
  end

  // products
  logic signed [17:0] w_s, wc_s;
  logic mp_vld;
  logic signed [49:0] mp_bg, mp_px;

  assign w_s = $signed({1'b0, wt_w});
  assign wc_s = $signed({1'b0, ONE_Q16 - wt_w});

  always_ff @(posedge clk) begin
    if (rst) begin
      mp_vld <= 1'b0;
    end else if (adv) begin
      mp_vld <= wt_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mp_bg <= background_level * w_s;
      mp_px <= wt_pix * wc_s;
    end
  end

  // sum and round
  logic signed [50:0] acc;
  assign acc = 51'(mp_bg) + 51'(mp_px) + 51'sd32768;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= mp_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= acc[47:16];
    end
  end

`include "assert_macros.svh"

  `ASSERT_CLK(a_ready_tracks_output, s_tready == (!m_tvalid || m_tready), "s_tready wrong")
  `ASSERT_CLK(a_weight_range, wt_vld |-> (wt_w <= ONE_Q16), "weight above one")
  `ASSERT_CLK(a_band_excludes_outer, s1_vld |-> !(s1_side.band && s1_side.outer), "band and outer")
  `ASSERT_ALWAYS(a_empty_after_reset, rst |=> !m_tvalid, "output valid after reset")

endmodule

`default_nettype wire

FILE: bench/rcsm_blend_checker.sv
`timescale 1ns / 1ps
// checker for the raised-cosine soft mask blend: follows apb register writes,
// predicts each masked value from accepted input items and compares the output
// depends on rcsm_pkg for register indexes, tdata width and cordic step count
module rcsm_blend_checker (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  input  logic pready,
  input  logic s_tvalid,
  input  logic s_tready,
  input  logic [rcsm_pkg::IN_TDATA_W-1:0] s_tdata,
  input  logic m_tvalid,
  input  logic m_tready,
  input  logic [31:0] m_tdata,
  output int mismatches,
  output int awaiting,
  output int blends_seen
);
  import rcsm_pkg::*;

  localparam longint GAIN = 652032874;
  localparam longint PI_FIX = 64'd3373259426;
  localparam longint ANGLES [16] = '{843314857, 497837830, 263043837, 133525159,
    67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768};

  logic [19:0] radius_q8;
  logic [19:0] edge_q8;
  logic signed [31:0] bg_level;
  logic alpha_mode;
  logic [31:0] expected_blends[$];

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // cosine of pi*frac/65536 in q2.15, frac at most one half
  function automatic longint cos_fix(input longint frac);
    longint x, y, z, xs, ys, c;
    x = GAIN;
    y = 0;
    if (frac == 0) return 32768;
    z = (frac * PI_FIX) >>> 16;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - ANGLES[i];
      end else begin
        x = x + ys; y = y - xs; z = z + ANGLES[i];
      end
    end
    c = (x + 16384) >>> 15;
    if (c > 32768) c = 32768;
    if (c < -32768) c = -32768;
    return c;
  endfunction

  function automatic longint radial_bg_weight(input longint cx, input longint cy,
                                              input longint cz);
    longint s, r, ew, outer, u, t, c;
    s = (cx * cx + cy * cy + cz * cz) << 16;
    r = radius_q8;
    ew = edge_q8;
    outer = r + ew;
    if (s > outer * outer) return 65536;
    if (s < r * r || ew == 0) return 0;
    u = int_sqrt(s);
    t = ((u - r) << 16) / ew;
    if (t > 65536) t = 65536;
    if (t > 32768) c = -cos_fix(65536 - t);
    else c = cos_fix(t);
    return 32768 - c;
  endfunction

  function automatic logic [31:0] blend_value(input logic [IN_TDATA_W-1:0] d);
    logic signed [11:0] col, row, slc;
    logic signed [31:0] pix;
    logic [16:0] alpha;
    longint w, acc;
    col = d[11:0];
    row = d[23:12];
    slc = d[35:24];
    pix = d[67:36];
    alpha = d[84:68];
    if (alpha_mode) w = 65536 - ((alpha > 17'd65536) ? 65536 : longint'(alpha));
    else w = radial_bg_weight(col, row, slc);
    acc = longint'(bg_level) * w + longint'(pix) * (65536 - w);
    acc = (acc + 32768) >>> 16;
    return acc[31:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  assign awaiting = expected_blends.size();

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst) begin
      radius_q8 <= '0;
      edge_q8 <= '0;
      bg_level <= '0;
      alpha_mode <= 1'b0;
      expected_blends.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_INNER: radius_q8 <= pwdata[19:0];
          REG_EDGE: edge_q8 <= pwdata[19:0];
          REG_BG: bg_level <= pwdata;
          REG_SRC: alpha_mode <= pwdata[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) expected_blends = {expected_blends, blend_value(s_tdata)};
      if (m_tvalid && m_tready) begin
        blends_seen++;
        if (expected_blends.size() == 0) begin
          report_mismatch($sformatf("unexpected masked value %h", m_tdata));
        end else begin
          want = expected_blends.pop_front();
          if (m_tdata !== want)
            report_mismatch($sformatf("masked value %h, expected %h", m_tdata, want));
        end
      end
    end
  end
endmodule

FILE: bench/tb_raised_cosine_soft_mask_blend.sv
`timescale 1ns / 1ps
// stimulus and verdict for the raised-cosine soft mask blend
// depends on rcsm_pkg, the block and rcsm_blend_checker
module tb_raised_cosine_soft_mask_blend;
  import rcsm_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;

  int mismatches, awaiting, blends_seen;
  int sent_items = 0;
  int cycles = 0;
  int src_idle = 0;
  int sink_idle = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  raised_cosine_soft_mask_blend i_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
  );

  rcsm_blend_checker i_checker (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .mismatches, .awaiting, .blends_seen
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    m_tready <= ($urandom_range(99) >= sink_idle);
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic set_mask(input logic [19:0] r, input logic [19:0] ew,
                          input logic [31:0] bg, input logic alpha_src);
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    write_reg(REG_INNER, {12'd0, r});
    write_reg(REG_EDGE, {12'd0, ew});
    write_reg(REG_BG, bg);
    write_reg(REG_SRC, {31'd0, alpha_src});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_pixel(input logic [11:0] col, input logic [11:0] row,
                            input logic [11:0] slc, input logic [31:0] pix,
                            input logic [16:0] alpha);
    // idling pattern changes with progress: receiver slow, then sender slow, then neither
    if (sent_items < RANDOM_ITEMS / 3) begin
      src_idle = 12; sink_idle = 59;
    end else if (sent_items < 2 * RANDOM_ITEMS / 3) begin
      src_idle = 59; sink_idle = 12;
    end else begin
      src_idle = 0; sink_idle = 0;
    end
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, alpha, pix, slc, row, col};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_items++;
  endtask

  task automatic random_pixels(input int n, input int reach_px);
    logic [31:0] pix;
    logic [16:0] alpha;
    int span;
    for (int k = 0; k < n; k++) begin
      pix = $urandom();
      alpha = ($urandom_range(3) == 0) ? 17'($urandom_range(131071))
                                       : 17'($urandom_range(65536));
      span = (reach_px > 2047) ? 2047 : reach_px;
      if ($urandom_range(7) == 0)
        send_pixel(12'($urandom()), 12'($urandom()), 12'($urandom()), pix, alpha);
      else
        send_pixel(12'(int'($urandom_range(2 * span)) - span),
                   12'(int'($urandom_range(2 * span)) - span),
                   $urandom_range(1) ? 12'(int'($urandom_range(2 * span)) - span) : 12'd0,
                   pix, alpha);
    end
    s_tvalid <= 1'b0;
  endtask

  task automatic random_phase(input logic [31:0] bg, input int n);
    int r_px, ew_px;
    r_px = $urandom_range(40);
    ew_px = $urandom_range(20);
    set_mask({r_px[11:0], 8'($urandom())}, {ew_px[11:0], 8'($urandom())}, bg, 1'b0);
    random_pixels(n, r_px + ew_px + 3);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // hard edge of ten pixels, plain mask: on the radius stays inside
    set_mask(20'd2560, 20'd0, 32'd0, 1'b0);
    send_pixel(12'd10, 12'd0, 12'd0, 32'd65536, 17'd0);
    send_pixel(12'd0, -12'sd10, 12'd0, 32'd65536, 17'd0);
    send_pixel(12'd11, 12'd0, 12'd0, 32'd65536, 17'd0);
    send_pixel(12'd0, 12'd0, 12'd0, 32'h7fff_ffff, 17'd0);
    send_pixel(12'd0, 12'd0, 12'd0, 32'h8000_0000, 17'd0);
    send_pixel(12'h800, 12'h800, 12'h800, 32'h8000_0000, 17'h1ffff);
    send_pixel(12'h7ff, 12'h7ff, 12'h7ff, 32'h7fff_ffff, 17'h1ffff);
    send_pixel(12'd6, 12'd8, 12'd0, 32'hffff_ffff, 17'd0);
    send_pixel(12'd6, 12'd8, 12'd1, 32'd1, 17'd0);
    s_tvalid <= 1'b0;
    // soft edge: band start, middle and end
    set_mask(20'd2560, 20'd2560, 32'h8000_0000, 1'b0);
    send_pixel(12'd10, 12'd0, 12'd0, 32'h7fff_ffff, 17'd0);
    send_pixel(12'd15, 12'd0, 12'd0, 32'h7fff_ffff, 17'd0);
    send_pixel(12'd20, 12'd0, 12'd0, 32'h7fff_ffff, 17'd0);
    send_pixel(12'd13, 12'd13, 12'd0, 32'h7fff_ffff, 17'd0);
    send_pixel(12'd12, 12'd0, 12'd5, 32'h8000_0000, 17'd0);
    s_tvalid <= 1'b0;
    // alpha weighting with alpha zero, one half, one and above one; coordinates ignored
    set_mask(20'd2560, 20'd2560, 32'h7fff_ffff, 1'b1);
    send_pixel(12'd0, 12'd0, 12'd0, 32'h8000_0000, 17'd0);
    send_pixel(12'h7ff, 12'd3, 12'd0, 32'h8000_0000, 17'd65536);
    send_pixel(12'd0, 12'h800, 12'd0, 32'h8000_0000, 17'd32768);
    send_pixel(12'd0, 12'd0, 12'd0, 32'h1234_5678, 17'h1ffff);
    send_pixel(12'd0, 12'd0, 12'd0, 32'h1234_5678, 17'd65537);
    s_tvalid <= 1'b0;
    sent_items = 0;

    set_mask(20'd0, 20'd0, 32'h7fff_ffff, 1'b0);
    random_pixels(RANDOM_ITEMS / 7, 6);
    random_phase($urandom(), RANDOM_ITEMS / 7);
    set_mask(20'($urandom()), 20'($urandom()), $urandom(), 1'b1);
    random_pixels(RANDOM_ITEMS / 7, 2047);
    set_mask(20'd524288, 20'd524288, $urandom(), 1'b0);
    random_pixels(RANDOM_ITEMS / 7, 2047);
    set_mask(20'hfffff, 20'hfffff, 32'h8000_0000, 1'b0);
    random_pixels(RANDOM_ITEMS / 14, 2047);
    random_phase(32'h8000_0000, RANDOM_ITEMS / 7);
    random_phase($urandom(), RANDOM_ITEMS / 7);
    random_phase(32'd0, RANDOM_ITEMS / 7);

    while (awaiting != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("covered hard and soft edges, alpha weighting and register extremes");
    $display("%0d random items sent, %0d masked values checked", sent_items, blends_seen);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
